[src/vma_pkg.sv]
// Package with the shared types and constants of the vector magnitude and angle block.
`timescale 1ns / 1ps
`default_nettype none
package vma_pkg;

    localparam int GUARD_BITS = 16;
    localparam int ZW         = 25;
    localparam int TW         = 26;
    localparam int MAX_STEPS  = 24;
    localparam int MAG_W      = 16;
    localparam int ANG_W      = 15;
    localparam int ANG_SHIFT  = 10;

    localparam logic signed [ZW-1:0] DEG_90_Z = ZW'(90 * 65536);
    localparam logic [TW-1:0] DEG_180   = TW'(180 * 65536);
    localparam logic [TW-1:0] DEG_360   = TW'(360 * 65536);
    localparam logic [TW-1:0] ROUND_HALF = TW'(512);

    localparam logic [MAG_W-1:0] MAG_MAX  = 16'hFFFF;
    localparam logic [MAG_W-1:0] ANG_FULL = 16'd23040;
    localparam logic [ANG_W-1:0] ANG_90   = 15'd5760;
    localparam logic [ANG_W-1:0] ANG_270  = 15'd17280;

    localparam logic signed [ZW-1:0] ATAN_TAB [MAX_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

    typedef struct packed {
        logic x_zero;
        logic x_neg;
        logic y_zero;
        logic y_neg;
    } t_flags;

endpackage
`default_nettype wire

[src/vma_if.sv]
// Handshake interfaces for the input vector and the polar result.
`timescale 1ns / 1ps
`default_nettype none
interface vma_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;

    modport source (output valid, output x_in, output y_in, input ready);
    modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

interface vma_out_if;
    logic                       valid;
    logic                       ready;
    logic [vma_pkg::MAG_W-1:0]  magnitude;
    logic [vma_pkg::ANG_W-1:0]  angle_deg;

    modport source (output valid, output magnitude, output angle_deg, input ready);
    modport sink   (input valid, input magnitude, input angle_deg, output ready);
endinterface
`default_nettype wire

[src/vector_magnitude_angle.sv]
// Top level of the Cartesian-to-polar converter built as a chain of CORDIC and root cells.
// The block takes one (x_in, y_in) transaction per cycle and returns its length, rounded to
// the nearest integer and saturated at 65535, and its direction in 1/64 degree, 0 to just
// under 360 degrees. Three front stages form |x|, |y| and x*x + y*y, then a row of cells
// each performs one CORDIC vectoring rotation (if its index is below ROTATION_STEPS) and
// produces one bit of the square root (if below COORD_WIDTH), and two back stages round the
// root, place the angle in its quadrant and round it. Every stage holds one transaction and
// moves forward whenever the stage after it has room, so throughput is one transaction per
// cycle as long as the result side takes them.
`timescale 1ns / 1ps
`default_nettype none
module vector_magnitude_angle #(
    parameter int COORD_WIDTH    = 16,
    parameter int ROTATION_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    vma_in_if.sink      i_vec,
    vma_out_if.source   o_polar
);

    localparam int W  = COORD_WIDTH;
    localparam int CW = W + 18;
    localparam int N  = (ROTATION_STEPS > W) ? ROTATION_STEPS : W;

    logic                          s_valid [N+1];
    logic                          s_ready [N+1];
    vma_pkg::t_flags               s_flags [N+1];
    logic signed [CW-1:0]          s_cx    [N+1];
    logic signed [CW-1:0]          s_cy    [N+1];
    logic signed [vma_pkg::ZW-1:0] s_z     [N+1];
    logic [2*W-1:0]                s_rad   [N+1];
    logic [W+1:0]                  s_rem   [N+1];
    logic [W-1:0]                  s_q     [N+1];
    logic [W-1:0]                  s_ax;
    logic [W-1:0]                  s_ay;

    vma_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vec.valid),
        .o_ready (i_vec.ready),
        .i_x     (i_vec.x_in),
        .i_y     (i_vec.y_in),
        .o_valid (s_valid[0]),
        .i_ready (s_ready[0]),
        .o_flags (s_flags[0]),
        .o_ax    (s_ax),
        .o_ay    (s_ay),
        .o_sum   (s_rad[0])
    );

    assign s_cx[0]  = $signed({2'b00, s_ax, vma_pkg::GUARD_BITS'(0)});
    assign s_cy[0]  = $signed({2'b00, s_ay, vma_pkg::GUARD_BITS'(0)});
    assign s_z[0]   = '0;
    assign s_rem[0] = '0;
    assign s_q[0]   = '0;

    generate
        for (genvar g = 0; g < N; g++) begin : g_cell
            vma_cell #(
                .W         (W),
                .STAGE     (g),
                .ROT_STEPS (ROTATION_STEPS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (s_valid[g]),
                .o_ready (s_ready[g]),
                .o_valid (s_valid[g+1]),
                .i_ready (s_ready[g+1]),
                .i_flags (s_flags[g]),
                .o_flags (s_flags[g+1]),
                .i_cx    (s_cx[g]),
                .i_cy    (s_cy[g]),
                .i_z     (s_z[g]),
                .i_rad   (s_rad[g]),
                .i_rem   (s_rem[g]),
                .i_q     (s_q[g]),
                .o_cx    (s_cx[g+1]),
                .o_cy    (s_cy[g+1]),
                .o_z     (s_z[g+1]),
                .o_rad   (s_rad[g+1]),
                .o_rem   (s_rem[g+1]),
                .o_q     (s_q[g+1])
            );
        end
    endgenerate

    vma_back #(.W(W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[N]),
        .o_ready (s_ready[N]),
        .i_flags (s_flags[N]),
        .i_z     (s_z[N]),
        .i_rem   (s_rem[N]),
        .i_q     (s_q[N]),
        .o_polar (o_polar)
    );

endmodule
`default_nettype wire

[src/vma_front.sv]
// Front stages: absolute values, squares and the sum of squares.
`timescale 1ns / 1ps
`default_nettype none
module vma_front #(
    parameter int W = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire signed [W-1:0]   i_x,
    input  wire signed [W-1:0]   i_y,
    output logic                 o_valid,
    input  wire                  i_ready,
    output vma_pkg::t_flags      o_flags,
    output logic [W-1:0]         o_ax,
    output logic [W-1:0]         o_ay,
    output logic [2*W-1:0]       o_sum
);

    logic [2:0]      r_valid;
    logic [2:0]      s_rdy;
    vma_pkg::t_flags r_flags [3];
    logic [W-1:0]    r_ax [3];
    logic [W-1:0]    r_ay [3];
    logic [2*W-1:0]  r_sqx;
    logic [2*W-1:0]  r_sqy;
    logic [2*W-1:0]  r_sum;
    logic [W-1:0]    n_ax;
    logic [W-1:0]    n_ay;
    vma_pkg::t_flags n_flags;

    assign s_rdy[2] = !r_valid[2] || i_ready;
    assign s_rdy[1] = !r_valid[1] || s_rdy[2];
    assign s_rdy[0] = !r_valid[0] || s_rdy[1];
    assign o_ready  = s_rdy[0];

    always_comb begin
        n_ax = i_x[W-1] ? W'(~i_x + 1'b1) : W'(i_x);
        n_ay = i_y[W-1] ? W'(~i_y + 1'b1) : W'(i_y);
        n_flags.x_zero = (i_x == '0);
        n_flags.x_neg  = i_x[W-1];
        n_flags.y_zero = (i_y == '0);
        n_flags.y_neg  = i_y[W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (s_rdy[0]) r_valid[0] <= i_valid;
            if (s_rdy[1]) r_valid[1] <= r_valid[0];
            if (s_rdy[2]) r_valid[2] <= r_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r_ax[0]    <= n_ax;
            r_ay[0]    <= n_ay;
            r_flags[0] <= n_flags;
        end
        if (s_rdy[1]) begin
            r_ax[1]    <= r_ax[0];
            r_ay[1]    <= r_ay[0];
            r_flags[1] <= r_flags[0];
            r_sqx      <= (2*W)'(r_ax[0]) * (2*W)'(r_ax[0]);
            r_sqy      <= (2*W)'(r_ay[0]) * (2*W)'(r_ay[0]);
        end
        if (s_rdy[2]) begin
            r_ax[2]    <= r_ax[1];
            r_ay[2]    <= r_ay[1];
            r_flags[2] <= r_flags[1];
            r_sum      <= r_sqx + r_sqy;
        end
    end

    assign o_valid = r_valid[2];
    assign o_flags = r_flags[2];
    assign o_ax    = r_ax[2];
    assign o_ay    = r_ay[2];
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

[src/vma_cell.sv]
// Chain cell: CORDIC vectoring rotation (STAGE < ROT_STEPS), root digit (STAGE < W).
`timescale 1ns / 1ps
`default_nettype none
module vma_cell #(
    parameter int W         = 16,
    parameter int STAGE     = 0,
    parameter int ROT_STEPS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    output logic                             o_valid,
    input  wire                              i_ready,
    input  vma_pkg::t_flags                  i_flags,
    output vma_pkg::t_flags                  o_flags,
    input  wire signed [W+17:0]              i_cx,
    input  wire signed [W+17:0]              i_cy,
    input  wire signed [vma_pkg::ZW-1:0]     i_z,
    input  wire [2*W-1:0]                    i_rad,
    input  wire [W+1:0]                      i_rem,
    input  wire [W-1:0]                      i_q,
    output logic signed [W+17:0]             o_cx,
    output logic signed [W+17:0]             o_cy,
    output logic signed [vma_pkg::ZW-1:0]    o_z,
    output logic [2*W-1:0]                   o_rad,
    output logic [W+1:0]                     o_rem,
    output logic [W-1:0]                     o_q
);

    localparam int CW = W + 18;

    logic                          r_valid;
    vma_pkg::t_flags               r_flags;
    logic signed [CW-1:0]          r_cx;
    logic signed [CW-1:0]          r_cy;
    logic signed [vma_pkg::ZW-1:0] r_z;
    logic [2*W-1:0]                r_rad;
    logic [W+1:0]                  r_rem;
    logic [W-1:0]                  r_q;
    logic signed [CW-1:0]          n_cx;
    logic signed [CW-1:0]          n_cy;
    logic signed [vma_pkg::ZW-1:0] n_z;
    logic [2*W-1:0]                n_rad;
    logic [W+1:0]                  n_rem;
    logic [W-1:0]                  n_q;

    assign o_ready = !r_valid || i_ready;

    generate
        if (STAGE < ROT_STEPS) begin : g_rot
            logic signed [CW-1:0] s_dx;
            logic signed [CW-1:0] s_dy;
            assign s_dx = i_cy >>> STAGE;
            assign s_dy = i_cx >>> STAGE;
            always_comb begin
                if (!i_cy[CW-1]) begin
                    n_cx = i_cx + s_dx;
                    n_cy = i_cy - s_dy;
                    n_z  = i_z + vma_pkg::ATAN_TAB[STAGE];
                end else begin
                    n_cx = i_cx - s_dx;
                    n_cy = i_cy + s_dy;
                    n_z  = i_z - vma_pkg::ATAN_TAB[STAGE];
                end
            end
        end else begin : g_rot_pass
            assign n_cx = i_cx;
            assign n_cy = i_cy;
            assign n_z  = i_z;
        end

        if (STAGE < W) begin : g_root
            logic [W+1:0] s_shift;
            logic [W+1:0] s_trial;
            assign s_shift = {i_rem[W-1:0], i_rad[2*W-1 -: 2]};
            assign s_trial = {i_q, 2'b01};
            assign n_rad   = {i_rad[2*W-3:0], 2'b00};
            always_comb begin
                if (s_shift >= s_trial) begin
                    n_rem = s_shift - s_trial;
                    n_q   = {i_q[W-2:0], 1'b1};
                end else begin
                    n_rem = s_shift;
                    n_q   = {i_q[W-2:0], 1'b0};
                end
            end
        end else begin : g_root_pass
            assign n_rad = i_rad;
            assign n_rem = i_rem;
            assign n_q   = i_q;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_flags <= i_flags;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_z     <= n_z;
            r_rad   <= n_rad;
            r_rem   <= n_rem;
            r_q     <= n_q;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_z     = r_z;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_q     = r_q;

endmodule
`default_nettype wire

[src/vma_back.sv]
// Back stages: root rounding and saturation, quadrant placement and angle rounding.
`timescale 1ns / 1ps
`default_nettype none
module vma_back #(
    parameter int W = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  vma_pkg::t_flags                  i_flags,
    input  wire signed [vma_pkg::ZW-1:0]     i_z,
    input  wire [W+1:0]                      i_rem,
    input  wire [W-1:0]                      i_q,
    vma_out_if.source                        o_polar
);

    localparam int MW = (W + 1 > 17) ? W + 1 : 17;
    localparam int TW = vma_pkg::TW;

    logic [1:0]                  r_valid;
    logic [1:0]                  s_rdy;
    logic [vma_pkg::MAG_W-1:0]   r_mag [2];
    logic [TW-1:0]               r_t;
    logic                        r_x_zero;
    logic                        r_y_pos;
    logic [vma_pkg::ANG_W-1:0]   r_ang;
    logic [W:0]                  s_root;
    logic [MW-1:0]               s_root_ext;
    logic [vma_pkg::MAG_W-1:0]   n_mag;
    logic signed [vma_pkg::ZW-1:0] s_zc;
    logic [TW-1:0]               s_za;
    logic [TW-1:0]               n_t;
    logic [TW-1:0]               s_tr;
    logic [vma_pkg::MAG_W-1:0]   s_ang;
    logic [vma_pkg::ANG_W-1:0]   n_ang;

    assign s_rdy[1] = !r_valid[1] || o_polar.ready;
    assign s_rdy[0] = !r_valid[0] || s_rdy[1];
    assign o_ready  = s_rdy[0];

    always_comb begin
        s_root     = {1'b0, i_q} + ((i_rem > (W+2)'(i_q)) ? (W+1)'(1) : (W+1)'(0));
        s_root_ext = MW'(s_root);
        if (s_root_ext > MW'(vma_pkg::MAG_MAX)) begin
            n_mag = vma_pkg::MAG_MAX;
        end else begin
            n_mag = s_root_ext[vma_pkg::MAG_W-1:0];
        end

        if (i_z < 0) begin
            s_zc = '0;
        end else if (i_z > vma_pkg::DEG_90_Z) begin
            s_zc = vma_pkg::DEG_90_Z;
        end else begin
            s_zc = i_z;
        end
        s_za = TW'($unsigned(s_zc));

        if (i_flags.x_neg) begin
            n_t = i_flags.y_neg ? vma_pkg::DEG_180 + s_za : vma_pkg::DEG_180 - s_za;
        end else begin
            n_t = i_flags.y_neg ? vma_pkg::DEG_360 - s_za : s_za;
        end
    end

    always_comb begin
        s_tr  = r_t + vma_pkg::ROUND_HALF;
        s_ang = s_tr[vma_pkg::ANG_SHIFT +: vma_pkg::MAG_W];
        if (r_x_zero) begin
            n_ang = r_y_pos ? vma_pkg::ANG_90 : vma_pkg::ANG_270;
        end else if (s_ang >= vma_pkg::ANG_FULL) begin
            n_ang = vma_pkg::ANG_W'(s_ang - vma_pkg::ANG_FULL);
        end else begin
            n_ang = s_ang[vma_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (s_rdy[0]) r_valid[0] <= i_valid;
            if (s_rdy[1]) r_valid[1] <= r_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r_mag[0] <= n_mag;
            r_t      <= n_t;
            r_x_zero <= i_flags.x_zero;
            r_y_pos  <= !i_flags.y_neg && !i_flags.y_zero;
        end
        if (s_rdy[1]) begin
            r_mag[1] <= r_mag[0];
            r_ang    <= n_ang;
        end
    end

    assign o_polar.valid     = r_valid[1];
    assign o_polar.magnitude = r_mag[1];
    assign o_polar.angle_deg = r_ang;

endmodule
`default_nettype wire

[src/vma_checker.sv]
// Port-level assertions for the converter and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module vma_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             i_in_ready,
    input wire                             i_out_valid,
    input wire                             i_out_ready,
    input wire [vma_pkg::MAG_W-1:0]        i_magnitude,
    input wire [vma_pkg::ANG_W-1:0]        i_angle_deg
);

    // A pending result disappears only when it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_angle_deg < vma_pkg::ANG_W'(vma_pkg::ANG_FULL)))
        else $error("angle out of range");

    // Only the origin has zero length, and its angle is 270 degrees.
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_magnitude == '0) |-> (i_angle_deg == vma_pkg::ANG_270))
        else $error("zero length with wrong angle");

    // The pipeline refuses input only when every stage is full and the result is stalled.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input refused while the pipeline has room");

endmodule

bind vector_magnitude_angle vma_checker u_vma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vec.valid),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_polar.valid),
    .i_out_ready (o_polar.ready),
    .i_magnitude (o_polar.magnitude),
    .i_angle_deg (o_polar.angle_deg)
);
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the Cartesian-to-polar converter vector_magnitude_angle.
`timescale 1ns / 1ps
module tb;

    localparam int COORD_W      = 16;
    localparam int STEPS        = 16;
    localparam int NUM_ROWS     = 23;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam longint DEG_UNIT   = 65536;
    localparam longint FULL_TURN  = 23040;
    localparam logic [vma_pkg::ANG_W-1:0] DIR_90  = 15'd5760;
    localparam logic [vma_pkg::ANG_W-1:0] DIR_270 = 15'd17280;
    localparam longint ARCTAN_UNITS [0:STEPS-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [vma_pkg::MAG_W-1:0] magnitude;
        logic [vma_pkg::ANG_W-1:0] angle;
    } t_polar;

    typedef struct packed {
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic                      known;
        logic [vma_pkg::MAG_W-1:0] magnitude;
        logic [vma_pkg::ANG_W-1:0] angle;
    } t_vec_row;

    // Rows with known set carry a result that needs no CORDIC run.
    localparam t_vec_row VECTOR_ROWS [0:NUM_ROWS-1] = '{
        '{0, 0, 1'b1, 0, DIR_270},
        '{0, 1, 1'b1, 1, DIR_90},
        '{0, -1, 1'b1, 1, DIR_270},
        '{0, 32767, 1'b1, 32767, DIR_90},
        '{0, -32768, 1'b1, 32768, DIR_270},
        '{1, 0, 1'b0, 0, 0},
        '{-1, 0, 1'b0, 0, 0},
        '{32767, 0, 1'b0, 0, 0},
        '{-32768, 0, 1'b0, 0, 0},
        '{32767, 32767, 1'b0, 0, 0},
        '{-32768, 32767, 1'b0, 0, 0},
        '{-32768, -32768, 1'b0, 0, 0},
        '{32767, -32768, 1'b0, 0, 0},
        '{1, 1, 1'b0, 0, 0},
        '{-1, 1, 1'b0, 0, 0},
        '{-1, -1, 1'b0, 0, 0},
        '{1, -1, 1'b0, 0, 0},
        '{3, 4, 1'b0, 0, 0},
        '{-32768, -1, 1'b0, 0, 0},
        '{32767, -1, 1'b0, 0, 0},
        '{1, -32768, 1'b0, 0, 0},
        '{-1, 32767, 1'b0, 0, 0},
        '{100, -1, 1'b0, 0, 0}
    };

    logic i_clk;
    logic i_rst_n;
    logic hold_off;
    int   in_idle_pct;
    int   out_idle_pct;
    int   sent_count;
    int   error_count;
    int   cycle_count;
    t_polar polar_expect [$];

    vma_in_if #(.COORD_WIDTH(COORD_W)) vec_if ();
    vma_out_if polar_if ();

    vector_magnitude_angle #(
        .COORD_WIDTH    (COORD_W),
        .ROTATION_STEPS (STEPS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec_if),
        .o_polar (polar_if)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_polar predict_polar(input logic signed [COORD_W-1:0] x,
                                             input logic signed [COORD_W-1:0] y);
        longint sx, sy, ax, ay, cx, cy, dx, dy, z, t, angv;
        longint unsigned rem, root, bitv;
        int i;
        t_polar res;
        sx = x;
        sy = y;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        rem = ax * ax + ay * ay;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (rem > root) root = root + 1;
        if (root > 65535) root = 65535;
        res.magnitude = root[vma_pkg::MAG_W-1:0];
        if (sx == 0) begin
            res.angle = (sy > 0) ? DIR_90 : DIR_270;
        end else begin
            cx = ax * DEG_UNIT;
            cy = ay * DEG_UNIT;
            z = 0;
            for (i = 0; i < STEPS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z = z + ARCTAN_UNITS[i];
                end else begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z = z - ARCTAN_UNITS[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 90 * DEG_UNIT) z = 90 * DEG_UNIT;
            if (sx < 0) t = (sy >= 0) ? 180 * DEG_UNIT - z : 180 * DEG_UNIT + z;
            else t = (sy >= 0) ? z : 360 * DEG_UNIT - z;
            angv = (t + 512) >>> 10;
            if (angv >= FULL_TURN) angv = angv - FULL_TURN;
            res.angle = angv[vma_pkg::ANG_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            2, 3: begin
                v = COORD_W'($urandom_range(16));
                if ($urandom_range(1)) v = -v;
            end
            default: v = COORD_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_vector(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input t_polar result);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            vec_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        vec_if.valid <= 1'b1;
        vec_if.x_in  <= x;
        vec_if.y_in  <= y;
        do @(posedge i_clk); while (!(vec_if.valid && vec_if.ready));
        polar_expect.push_back(result);
        sent_count++;
    endtask

    task automatic push_random(input int count);
        logic [COORD_W-1:0] x, y;
        int n;
        for (n = 0; n < count; n++) begin
            x = pick_coord();
            case ($urandom_range(9))
                0: y = x;
                1: y = -x;
                default: y = pick_coord();
            endcase
            push_vector(x, y, predict_polar(x, y));
        end
    endtask

    task automatic report_mismatch(input t_polar want, input logic have_want);
        error_count++;
        if (error_count <= 10) begin
            if (have_want)
                $display("mismatch: magnitude %0d angle %0d, expected %0d angle %0d",
                         polar_if.magnitude, polar_if.angle_deg,
                         want.magnitude, want.angle);
            else
                $display("unexpected transaction: magnitude %0d angle %0d",
                         polar_if.magnitude, polar_if.angle_deg);
        end
    endtask

    always @(posedge i_clk) begin
        t_polar want;
        if (!i_rst_n) polar_if.ready <= 1'b0;
        else polar_if.ready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
        if (i_rst_n && polar_if.valid && polar_if.ready) begin
            if (polar_expect.size() == 0) begin
                report_mismatch(want, 1'b0);
            end else begin
                want = polar_expect.pop_front();
                if (polar_if.magnitude !== want.magnitude || polar_if.angle_deg !== want.angle)
                    report_mismatch(want, 1'b1);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver stops for a long stretch so that the pipeline fills and stalls its input.
    initial begin
        hold_off <= 1'b0;
        wait (sent_count >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int r;
        t_polar result;
        sent_count   = 0;
        error_count  = 0;
        cycle_count  = 0;
        i_rst_n      <= 1'b0;
        vec_if.valid <= 1'b0;
        vec_if.x_in  <= '0;
        vec_if.y_in  <= '0;
        in_idle_pct  <= 38;
        out_idle_pct <= 38;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++) begin
            if (VECTOR_ROWS[r].known)
                result = '{VECTOR_ROWS[r].magnitude, VECTOR_ROWS[r].angle};
            else
                result = predict_polar(VECTOR_ROWS[r].x, VECTOR_ROWS[r].y);
            push_vector(VECTOR_ROWS[r].x, VECTOR_ROWS[r].y, result);
        end

        push_random(700);
        in_idle_pct  <= 0;
        out_idle_pct <= 0;
        push_random(400);
        in_idle_pct  <= 38;
        out_idle_pct <= 38;
        push_random(530);

        vec_if.valid <= 1'b0;
        while (polar_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && polar_expect.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
